### design/bspe_pkg.sv
// Shared constants, codes and types for the bounded stack with positional edit.
package bspe_pkg;

  localparam int DEPTH   = 128;
  localparam int WORD_W  = 32;
  localparam int ACT_W   = 3;
  localparam int POS_W   = 7;
  localparam int ST_W    = 2;
  localparam int FILL_W  = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP   = 16;
  localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;
  localparam int PAD     = NGROUPS * GROUP;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t ERR_WORD = '1;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic             apply;
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] rd_addr;
    word_t            value;
  } cmd_t;

endpackage

### design/bspe_if.sv
// Request and response channel interfaces of the stack.
interface bspe_req_if import bspe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface bspe_rsp_if import bspe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [ST_W-1:0]          status;
  logic [FILL_W-1:0]        fill_count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, read_value, status, fill_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, read_value, status, fill_count, is_empty, is_full,
                  output ready);
endinterface

### design/bounded_stack_with_positional_edit_top.sv
// Top level: controller, cell row and read tree of the bounded stack.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | action, value, position
//   rsp     | out | valid / ready | read_value, status, fill_count, is_empty, is_full
//
// Each operation passes through accept and decode, a registered OR tree over
// the cell row (groups of GROUP cells), then apply the shift and load the result.
// Shifts happen in all cells at once in the apply cycle.
// rst (synchronous) empties the stack; stored words are not cleared.
// A stalled rsp holds the apply cycle; req is taken again once it completes.
module bounded_stack_with_positional_edit_top import bspe_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bspe_req_if.sink       req,
  bspe_rsp_if.source     rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;

  // latched operation
  logic             op_ins, op_del, op_read, op_inc, op_dec, op_err;
  logic [ST_W-1:0]  op_st;
  logic [CMP_W-1:0] op_pos, op_rd_addr;
  word_t            op_value;

  // decode of the incoming request
  logic             d_ins, d_del, d_read, d_inc, d_dec, d_err;
  logic [ST_W-1:0]  d_st;
  logic [CMP_W-1:0] d_pos, d_rd_addr;
  logic [CMP_W-1:0] cntx, posx;
  logic             full, empty;

  cmd_t             cmd;
  word_t            words [PAD];
  word_t            hits  [PAD];
  word_t            partial [NGROUPS];
  word_t            partial_next [NGROUPS];
  word_t            rd_word;
  logic [CNT_W-1:0] cnt_next;
  logic             go;

  assign req.ready = (state == S_IDLE);

  assign cntx  = CMP_W'(cnt);
  assign posx  = CMP_W'(req.position);
  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    d_ins     = 1'b0;
    d_del     = 1'b0;
    d_read    = 1'b0;
    d_inc     = 1'b0;
    d_dec     = 1'b0;
    d_err     = 1'b0;
    d_st      = ST_OK;
    d_pos     = posx;
    d_rd_addr = cntx - CMP_W'(1);
    unique case (req.action)
      ACT_PUSH: begin
        if (full) begin
          d_err = 1'b1; d_st = ST_OVERFLOW;
        end else begin
          d_ins = 1'b1; d_inc = 1'b1; d_pos = cntx;
        end
      end
      ACT_POP: begin
        if (empty) begin
          d_err = 1'b1; d_st = ST_UNDERFLOW;
        end else begin
          d_read = 1'b1; d_dec = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (empty) begin
          d_err = 1'b1; d_st = ST_UNDERFLOW;
        end else begin
          d_read = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          d_err = 1'b1; d_st = ST_OVERFLOW;
        end else if (posx > cntx) begin
          d_err = 1'b1; d_st = ST_BADPOS;
        end else begin
          d_ins = 1'b1; d_inc = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (empty) begin
          d_err = 1'b1; d_st = ST_UNDERFLOW;
        end else if (posx >= cntx) begin
          d_err = 1'b1; d_st = ST_BADPOS;
        end else begin
          d_read = 1'b1; d_dec = 1'b1; d_del = 1'b1; d_rd_addr = posx;
        end
      end
      default: ;
    endcase
  end

  // apply only when the result register can take the result
  assign go = (state == S_APPLY) && (!rsp.valid || rsp.ready);

  always_comb begin
    cmd.apply   = go;
    cmd.ins     = op_ins;
    cmd.del     = op_del;
    cmd.pos     = op_pos;
    cmd.rd_addr = op_rd_addr;
    cmd.value   = op_value;
  end

  for (genvar i = 0; i < PAD; i++) begin : g_row
    if (i < DEPTH) begin : g_cell
      bspe_cell u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .index (CMP_W'(i)),
        .lower ((i == 0) ? word_t'(0) : words[(i == 0) ? 0 : i - 1]),
        .upper ((i == DEPTH - 1) ? word_t'(0) : words[(i == DEPTH - 1) ? i : i + 1]),
        .word  (words[i]),
        .hit   (hits[i])
      );
    end else begin : g_pad
      assign words[i] = '0;
      assign hits[i]  = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      partial_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        partial_next[g] = partial_next[g] | hits[g * GROUP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      partial <= partial_next;
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rd_word = rd_word | partial[g];
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (op_inc) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (op_dec) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_ins     <= d_ins;
      op_del     <= d_del;
      op_read    <= d_read;
      op_inc     <= d_inc;
      op_dec     <= d_dec;
      op_err     <= d_err;
      op_st      <= d_st;
      op_pos     <= d_pos;
      op_rd_addr <= d_rd_addr;
      op_value   <= req.value;
    end
    if (go) begin
      rsp.read_value <= op_err ? ERR_WORD : (op_read ? rd_word : word_t'(0));
      rsp.status     <= op_st;
      rsp.fill_count <= FILL_W'(cnt_next);
      rsp.is_empty   <= (cnt_next == '0);
      rsp.is_full    <= (cnt_next == CNT_W'(DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (req.valid) state <= S_READ;
        S_READ:  state <= S_APPLY;
        S_APPLY: if (go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (go) begin
        cnt       <= cnt_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_read_then_apply: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_APPLY)
    else $error("read tree cycle not followed by apply");

  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_APPLY)
    else $error("result raised outside apply");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_APPLY |=> $stable(cnt))
    else $error("fill count moved outside apply");

endmodule

### design/bspe_cell.sv
// One storage cell of the stack row: holds a word, shifts with its neighbors.
module bspe_cell import bspe_pkg::*; (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [CMP_W-1:0] index,
  input  word_t            lower,
  input  word_t            upper,
  output word_t            word,
  output word_t            hit
);

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (cmd.ins) begin
        if (index == cmd.pos) begin
          word <= cmd.value;
        end else if (index > cmd.pos) begin
          word <= lower;
        end
      end else if (cmd.del && (index >= cmd.pos)) begin
        word <= upper;
      end
    end
  end

  // Drive the word onto the read tree only when addressed
  assign hit = (index == cmd.rd_addr) ? word : '0;

endmodule

### sim/tb_bounded_stack_with_positional_edit_top.sv
// Testbench for the bounded stack with positional edit: directed table, random ops, scoreboard.
`timescale 1ns / 100ps

module tb_bounded_stack_with_positional_edit_top import bspe_pkg::*; ();

  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  localparam int DIR_N = 24;
  localparam int ITEMS = 1350;

  typedef struct packed {
    word_t             rd;
    logic [ST_W-1:0]   st;
    logic [FILL_W-1:0] fill;
    logic              empty;
    logic              full;
  } stack_rsp_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    word_t            val;
    logic [POS_W-1:0] pos;
    logic             fixed;  // use the typed-in response instead of the prediction
    stack_rsp_t       rsp;
  } op_row_t;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_BALANCE} op_mix_t;

  localparam stack_rsp_t NO_RSP = '0;

  logic clk;
  logic rst;

  bspe_req_if req_bus ();
  bspe_rsp_if rsp_bus ();

  bounded_stack_with_positional_edit_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Predicted stack contents
  word_t      stk_words [DEPTH];
  int         stk_fill;
  stack_rsp_t rsp_expect_q [$];
  int         err_count;

  // Directed walk: empty-stack errors, spare codes, extremes, positional edge cases
  op_row_t dir_tbl [DIR_N] = '{
    '{ACT_POP,    32'sd0,           7'd0,   1'b1, '{ERR_WORD, ST_UNDERFLOW, 8'd0, 1'b1, 1'b0}},
    '{ACT_PEEK,   32'sd0,           7'd0,   1'b1, '{ERR_WORD, ST_UNDERFLOW, 8'd0, 1'b1, 1'b0}},
    '{ACT_DELETE, 32'sd0,           7'd0,   1'b1, '{ERR_WORD, ST_UNDERFLOW, 8'd0, 1'b1, 1'b0}},
    '{ACT_INSERT, 32'sd5,           7'd1,   1'b1, '{ERR_WORD, ST_BADPOS,    8'd0, 1'b1, 1'b0}},
    '{ACT_INSERT, -32'sd1,          7'd127, 1'b1, '{ERR_WORD, ST_BADPOS,    8'd0, 1'b1, 1'b0}},
    '{ACT_RSVD5,  32'sd0,           7'd0,   1'b1, '{32'sd0,   ST_OK,        8'd0, 1'b1, 1'b0}},
    '{ACT_RSVD6,  -32'sd1,          7'd127, 1'b1, '{32'sd0,   ST_OK,        8'd0, 1'b1, 1'b0}},
    '{ACT_RSVD7,  32'sh5A5A_5A5A,   7'd64,  1'b1, '{32'sd0,   ST_OK,        8'd0, 1'b1, 1'b0}},
    '{ACT_INSERT, 32'sh7FFF_FFFF,   7'd0,   1'b1, '{32'sd0,   ST_OK,        8'd1, 1'b0, 1'b0}},
    '{ACT_PUSH,   32'sh8000_0000,   7'd127, 1'b1, '{32'sd0,   ST_OK,        8'd2, 1'b0, 1'b0}},
    '{ACT_PEEK,   32'sd0,           7'd0,   1'b1, '{32'sh8000_0000, ST_OK,  8'd2, 1'b0, 1'b0}},
    '{ACT_PUSH,   -32'sd1,          7'd0,   1'b1, '{32'sd0,   ST_OK,        8'd3, 1'b0, 1'b0}},
    '{ACT_INSERT, 32'sh5555_5555,   7'd1,   1'b0, NO_RSP},
    '{ACT_INSERT, 32'shAAAA_AAAA,   7'd4,   1'b0, NO_RSP},
    '{ACT_INSERT, 32'sd0,           7'd6,   1'b1, '{ERR_WORD, ST_BADPOS,    8'd5, 1'b0, 1'b0}},
    '{ACT_DELETE, 32'sd0,           7'd5,   1'b1, '{ERR_WORD, ST_BADPOS,    8'd5, 1'b0, 1'b0}},
    '{ACT_DELETE, 32'sd0,           7'd127, 1'b1, '{ERR_WORD, ST_BADPOS,    8'd5, 1'b0, 1'b0}},
    '{ACT_DELETE, 32'sd0,           7'd1,   1'b0, NO_RSP},
    '{ACT_DELETE, 32'sd0,           7'd0,   1'b0, NO_RSP},
    '{ACT_RSVD5,  32'sd1234,        7'd2,   1'b0, NO_RSP},
    '{ACT_POP,    32'sd0,           7'd0,   1'b0, NO_RSP},
    '{ACT_POP,    32'sd0,           7'd0,   1'b0, NO_RSP},
    '{ACT_POP,    32'sd0,           7'd0,   1'b0, NO_RSP},
    '{ACT_POP,    32'sd0,           7'd0,   1'b1, '{ERR_WORD, ST_UNDERFLOW, 8'd0, 1'b1, 1'b0}}
  };

  // Apply one operation to the predicted stack and return its response
  function automatic stack_rsp_t stack_apply(input logic [ACT_W-1:0] act, input word_t val,
                                             input logic [POS_W-1:0] pos);
    stack_rsp_t r;
    int         p;
    p    = int'(pos);
    r.rd = '0;
    r.st = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (stk_fill >= DEPTH) begin
          r.rd = ERR_WORD;
          r.st = ST_OVERFLOW;
        end else begin
          stk_words[stk_fill] = val;
          stk_fill++;
        end
      end
      ACT_POP: begin
        if (stk_fill == 0) begin
          r.rd = ERR_WORD;
          r.st = ST_UNDERFLOW;
        end else begin
          stk_fill--;
          r.rd = stk_words[stk_fill];
        end
      end
      ACT_PEEK: begin
        if (stk_fill == 0) begin
          r.rd = ERR_WORD;
          r.st = ST_UNDERFLOW;
        end else begin
          r.rd = stk_words[stk_fill-1];
        end
      end
      ACT_INSERT: begin
        if (stk_fill >= DEPTH) begin
          r.rd = ERR_WORD;
          r.st = ST_OVERFLOW;
        end else if (p > stk_fill) begin
          r.rd = ERR_WORD;
          r.st = ST_BADPOS;
        end else begin
          for (int i = stk_fill; i > p; i--) stk_words[i] = stk_words[i-1];
          stk_words[p] = val;
          stk_fill++;
        end
      end
      ACT_DELETE: begin
        if (stk_fill == 0) begin
          r.rd = ERR_WORD;
          r.st = ST_UNDERFLOW;
        end else if (p >= stk_fill) begin
          r.rd = ERR_WORD;
          r.st = ST_BADPOS;
        end else begin
          r.rd = stk_words[p];
          for (int i = p; i + 1 < stk_fill; i++) stk_words[i] = stk_words[i+1];
          stk_fill--;
        end
      end
      default: ;
    endcase
    r.fill  = FILL_W'(stk_fill);
    r.empty = (stk_fill == 0);
    r.full  = (stk_fill == DEPTH);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_bounded_stack_with_positional_edit_top: errors");
    $finish;
  end

  // Response side: stall pattern and scoreboard
  initial begin
    int         mode;
    int         mode_left;
    int         phase;
    stack_rsp_t want;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        if (rsp_expect_q.size() == 0) begin
          report_mismatch("response with nothing outstanding", rsp_bus.read_value, '0);
        end else begin
          want = rsp_expect_q.pop_front();
          if (rsp_bus.read_value !== want.rd)
            report_mismatch("read_value", rsp_bus.read_value, want.rd);
          if (rsp_bus.status !== want.st)
            report_mismatch("status", 32'(rsp_bus.status), 32'(want.st));
          if (rsp_bus.fill_count !== want.fill)
            report_mismatch("fill_count", 32'(rsp_bus.fill_count), 32'(want.fill));
          if (rsp_bus.is_empty !== want.empty)
            report_mismatch("is_empty", 32'(rsp_bus.is_empty), 32'(want.empty));
          if (rsp_bus.is_full !== want.full)
            report_mismatch("is_full", 32'(rsp_bus.is_full), 32'(want.full));
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      phase++;
      case (mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= 1'($urandom_range(0, 1));
        2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_bus.ready <= (phase % 3 != 0);
      endcase
    end
  end

  // Request side: directed table, then random ops in bursts
  initial begin
    op_row_t    row;
    stack_rsp_t got_pred;
    op_mix_t    mix;
    int         mix_left;
    int         burst_left;
    int         gap;
    int         r;
    rst             <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.action   <= ACT_PUSH;
    req_bus.value    <= '0;
    req_bus.position <= '0;
    err_count  = 0;
    stk_fill   = 0;
    burst_left = 0;
    mix        = MIX_GROW;
    mix_left   = 250;  // start by filling up so overflow shows early
    foreach (stk_words[k]) stk_words[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < ITEMS; n++) begin
      if (n < DIR_N) begin
        row = dir_tbl[n];
      end else begin
        if (mix_left == 0) begin
          mix      = op_mix_t'($urandom_range(0, 2));
          mix_left = $urandom_range(60, 250);
        end else begin
          mix_left--;
        end
        r = $urandom_range(0, 99);
        case (mix)
          MIX_GROW:   row.act = (r < 45) ? ACT_PUSH : (r < 80) ? ACT_INSERT :
                                (r < 88) ? ACT_POP : (r < 95) ? ACT_DELETE :
                                (r < 97) ? ACT_PEEK : ACT_RSVD5 + ACT_W'($urandom_range(0, 2));
          MIX_SHRINK: row.act = (r < 8) ? ACT_PUSH : (r < 15) ? ACT_INSERT :
                                (r < 50) ? ACT_POP : (r < 85) ? ACT_DELETE :
                                (r < 95) ? ACT_PEEK : ACT_RSVD5 + ACT_W'($urandom_range(0, 2));
          default:    row.act = (r < 20) ? ACT_PUSH : (r < 40) ? ACT_INSERT :
                                (r < 60) ? ACT_POP : (r < 80) ? ACT_DELETE :
                                (r < 95) ? ACT_PEEK : ACT_RSVD5 + ACT_W'($urandom_range(0, 2));
        endcase
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: row.val = '0;
            1: row.val = '1;
            2: row.val = 32'sh8000_0000;
            default: row.val = 32'sh7FFF_FFFF;
          endcase
        end else begin
          row.val = word_t'($urandom);
        end
        // Keep most positions in range; the rest are drawn at random and may hit the bad-position path
        if ($urandom_range(0, 99) < 15)
          row.pos = POS_W'($urandom_range(0, 127));
        else if (row.act == ACT_INSERT)
          row.pos = POS_W'((stk_fill >= 127) ? $urandom_range(0, 127)
                                             : $urandom_range(0, stk_fill));
        else if (row.act == ACT_DELETE && stk_fill > 0)
          row.pos = POS_W'($urandom_range(0, stk_fill - 1));
        else
          row.pos = POS_W'($urandom_range(0, 127));
        row.fixed = 1'b0;
        row.rsp   = NO_RSP;
      end

      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          req_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;

      req_bus.valid    <= 1'b1;
      req_bus.action   <= row.act;
      req_bus.value    <= row.val;
      req_bus.position <= row.pos;
      do @(posedge clk); while (!req_bus.ready);

      got_pred = stack_apply(row.act, row.val, row.pos);
      rsp_expect_q.push_back(row.fixed ? row.rsp : got_pred);
    end
    req_bus.valid <= 1'b0;

    while (rsp_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_bounded_stack_with_positional_edit_top: clean");
    end else begin
      $display("tb_bounded_stack_with_positional_edit_top: errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/bspe_pkg.sv
design/bspe_if.sv
design/bspe_cell.sv
design/bounded_stack_with_positional_edit_top.sv
sim/tb_bounded_stack_with_positional_edit_top.sv
